### design/dmr_pkg.sv
// Package for the dead-man relay test controller.
// Holds word types, op and reply codes and sizing constants; no dependencies.
package dmr_pkg;

  localparam int unsigned RelayCount = 16;
  localparam int unsigned ImageWidth = 16;
  localparam logic [7:0] MaxIndex = 8'd15;
  localparam logic [ImageWidth-1:0] ImageAllOff = 16'hFFFF;
  localparam logic [15:0] HoldTimeoutReset = 16'd400;
  localparam logic [15:0] HardCapReset = 16'd10000;

  typedef enum logic [2:0] {
    OP_TICK    = 3'd0,
    OP_ENTER   = 3'd1,
    OP_EXIT    = 3'd2,
    OP_RELEASE = 3'd3,
    OP_HOLD    = 3'd4,
    OP_STOP    = 3'd5
  } op_e;

  typedef enum logic [2:0] {
    RPL_NONE      = 3'd0,
    RPL_ENTER_ACK = 3'd1,
    RPL_BUSY      = 3'd2,
    RPL_EXIT_DONE = 3'd3,
    RPL_INVALID   = 3'd4,
    RPL_CAP       = 3'd5,
    RPL_STOP_DONE = 3'd6
  } reply_e;

  typedef enum logic {
    CFG_HOLD_TIMEOUT = 1'b0,
    CFG_HARD_CAP     = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    op_e        op;
    logic [7:0] relay_index;
    logic       seq_busy;
  } in_t;

  typedef struct packed {
    logic [ImageWidth-1:0] relays;
    reply_e                reply_code;
    logic                  in_test_mode;
    logic                  held_valid;
    logic [3:0]            held_index;
    logic                  cap_hit;
  } out_t;

  typedef struct packed {
    logic [15:0] hold_timeout;
    logic [15:0] hard_cap;
  } cfg_t;

endpackage

### design/dmr_ctrl.sv
// Interlock state and single-pass update logic for one command word.
// Depends on dmr_pkg for word types, codes and constants.
module dmr_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          step_i,
  input  dmr_pkg::in_t  item_i,
  input  dmr_pkg::cfg_t cfg_i,
  output dmr_pkg::out_t result_o
);

  logic [dmr_pkg::ImageWidth-1:0] image_q, image_d;
  logic        mode_q, mode_d;
  logic        sel_valid_q, sel_valid_d;
  logic [3:0]  sel_index_q, sel_index_d;
  logic        capped_q, capped_d;
  logic [15:0] on_elapsed_q, on_elapsed_d;
  logic [15:0] since_hold_q, since_hold_d;
  dmr_pkg::reply_e reply;

  logic [15:0] on_inc, sh_inc;
  logic [dmr_pkg::ImageWidth-1:0] sel_bit;
  logic idx_ok;

  assign on_inc  = (on_elapsed_q == 16'hFFFF) ? on_elapsed_q : on_elapsed_q + 16'd1;
  assign sh_inc  = (since_hold_q == 16'hFFFF) ? since_hold_q : since_hold_q + 16'd1;
  assign sel_bit = dmr_pkg::ImageWidth'(1) << sel_index_q;
  assign idx_ok  = (item_i.relay_index < 8'(dmr_pkg::RelayCount)) &&
                   (item_i.relay_index <= dmr_pkg::MaxIndex);

  always_comb begin
    image_d      = image_q;
    mode_d       = mode_q;
    sel_valid_d  = sel_valid_q;
    sel_index_d  = sel_index_q;
    capped_d     = capped_q;
    on_elapsed_d = on_elapsed_q;
    since_hold_d = since_hold_q;
    reply        = dmr_pkg::RPL_NONE;
    unique case (item_i.op)
      dmr_pkg::OP_TICK: begin
        if (mode_q && sel_valid_q) begin
          on_elapsed_d = on_inc;
          since_hold_d = sh_inc;
          if (!capped_q && on_inc >= cfg_i.hard_cap) begin
            image_d  = image_d | sel_bit;
            capped_d = 1'b1;
            reply    = dmr_pkg::RPL_CAP;
          end
          // keep-alive expired: drop the selection
          if (sh_inc > cfg_i.hold_timeout) begin
            if (!capped_d) begin
              image_d = image_d | sel_bit;
            end
            sel_valid_d = 1'b0;
            capped_d    = 1'b0;
          end
        end
      end
      dmr_pkg::OP_ENTER: begin
        if (item_i.seq_busy) begin
          reply = dmr_pkg::RPL_BUSY;
        end else begin
          image_d     = dmr_pkg::ImageAllOff;
          mode_d      = 1'b1;
          sel_valid_d = 1'b0;
          capped_d    = 1'b0;
          reply       = dmr_pkg::RPL_ENTER_ACK;
        end
      end
      dmr_pkg::OP_EXIT: begin
        image_d     = dmr_pkg::ImageAllOff;
        mode_d      = 1'b0;
        sel_valid_d = 1'b0;
        reply       = dmr_pkg::RPL_EXIT_DONE;
      end
      dmr_pkg::OP_RELEASE: begin
        if (sel_valid_q) begin
          image_d = image_q | sel_bit;
        end
        sel_valid_d = 1'b0;
        capped_d    = 1'b0;
      end
      dmr_pkg::OP_HOLD: begin
        if (mode_q) begin
          if (!idx_ok) begin
            reply = dmr_pkg::RPL_INVALID;
          end else begin
            if (!sel_valid_q || item_i.relay_index[3:0] != sel_index_q) begin
              image_d = dmr_pkg::ImageAllOff &
                        ~(dmr_pkg::ImageWidth'(1) << item_i.relay_index[3:0]);
              sel_valid_d  = 1'b1;
              sel_index_d  = item_i.relay_index[3:0];
              on_elapsed_d = '0;
              capped_d     = 1'b0;
            end
            since_hold_d = '0;
          end
        end
      end
      dmr_pkg::OP_STOP: begin
        image_d     = dmr_pkg::ImageAllOff;
        mode_d      = 1'b0;
        sel_valid_d = 1'b0;
        capped_d    = 1'b0;
        reply       = dmr_pkg::RPL_STOP_DONE;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      image_q      <= dmr_pkg::ImageAllOff;
      mode_q       <= 1'b0;
      sel_valid_q  <= 1'b0;
      sel_index_q  <= '0;
      capped_q     <= 1'b0;
      on_elapsed_q <= '0;
      since_hold_q <= '0;
    end else if (step_i) begin
      image_q      <= image_d;
      mode_q       <= mode_d;
      sel_valid_q  <= sel_valid_d;
      sel_index_q  <= sel_index_d;
      capped_q     <= capped_d;
      on_elapsed_q <= on_elapsed_d;
      since_hold_q <= since_hold_d;
    end
  end

  always_comb begin
    result_o.relays       = image_d;
    result_o.reply_code   = reply;
    result_o.in_test_mode = mode_d;
    result_o.held_valid   = sel_valid_d;
    result_o.held_index   = sel_valid_d ? sel_index_d : 4'd0;
    result_o.cap_hit      = capped_d;
  end

`ifndef SYNTHESIS
  // a selection only exists inside test mode
  a_sel_needs_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sel_valid_q |-> mode_q)
    else $error("selection held outside test mode");
  // a hold of a valid index selects that relay and leaves it on unless capped
  a_hold_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && item_i.op == dmr_pkg::OP_HOLD && mode_q && idx_ok) |=>
    (sel_valid_q && since_hold_q == 16'd0 && image_q[sel_index_q] == (1'b0 || capped_q)))
    else $error("hold did not select the relay");
  // at most one relay is ever on
  a_one_on: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(~image_q) <= 1)
    else $error("more than one relay on");
`endif

endmodule

### design/dead_man_relay_test_controller.sv
// Top level of the dead-man relay test controller: config registers,
// input word register and result word register around dmr_ctrl. Uses dmr_pkg.
//
// Each command word passes an input register, one pass of update logic and a
// result register. A new word is taken every cycle, limited only by the
// result side's stall. The input stalls only while its register is full and
// the result register cannot drain.
// Config writes take effect on the next cycle and are meant for idle periods.
module dead_man_relay_test_controller (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  dmr_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output dmr_pkg::out_t out_data_o,
  input  logic          cfg_we_i,
  input  logic          cfg_index_i,
  input  logic [15:0]   cfg_data_i
);

  dmr_pkg::cfg_t cfg_q;
  dmr_pkg::in_t  item_q;
  logic          item_valid_q;
  logic          out_valid_q;
  dmr_pkg::out_t out_q;
  dmr_pkg::out_t result;
  logic          out_free;
  logic          step;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign step       = item_valid_q && out_free;
  assign in_stall_o = item_valid_q && !out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.hold_timeout <= dmr_pkg::HoldTimeoutReset;
      cfg_q.hard_cap     <= dmr_pkg::HardCapReset;
    end else if (cfg_we_i) begin
      unique case (dmr_pkg::cfg_idx_e'(cfg_index_i))
        dmr_pkg::CFG_HOLD_TIMEOUT: cfg_q.hold_timeout <= cfg_data_i;
        dmr_pkg::CFG_HARD_CAP:     cfg_q.hard_cap     <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // input register: refill whenever the held word moves on or it is empty
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      item_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      item_q <= in_data_i;
    end
  end

  dmr_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .item_i   (item_q),
    .cfg_i    (cfg_q),
    .result_o (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= item_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  a_stall_needs_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (item_valid_q && out_valid_q && out_stall_i))
    else $error("input stalled without a blocked result");
  a_held_index_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_data_o.held_valid) |-> (out_data_o.held_index == 4'd0))
    else $error("held index set without a selection");
  a_word_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step |=> out_valid_q)
    else $error("stepped word did not reach the result register");
`endif

endmodule

### tb/sv/dead_man_relay_test_controller_tb.sv
// Testbench for the dead-man relay test controller: directed and random command
// words, random idling on both channels, and an in-bench relay predictor.
// Depends on dmr_pkg and dead_man_relay_test_controller.
`timescale 1ns / 1ps

module dead_man_relay_test_controller_tb;
  import dmr_pkg::*;

  localparam int CycleLimit = 2_000_000;
  localparam int InWidth = $bits(in_t);
  localparam logic [15:0] CountMax = 16'hFFFF;
  localparam logic [2:0] OpSpareLo = 3'd6;
  localparam logic [2:0] OpSpareHi = 3'd7;

  class relay_tracker;
    logic [15:0] timeout_ticks;
    logic [15:0] cap_ticks;
    logic [15:0] image;
    bit mode_on;
    bit sel_on;
    logic [3:0] sel_idx;
    bit capped;
    logic [15:0] on_ticks;
    logic [15:0] idle_ticks;
    out_t due_results[$];
    int fails;

    function new();
      timeout_ticks = HoldTimeoutReset;
      cap_ticks = HardCapReset;
      image = ImageAllOff;
      mode_on = 0;
      sel_on = 0;
      sel_idx = '0;
      capped = 0;
      on_ticks = '0;
      idle_ticks = '0;
      fails = 0;
    endfunction

    function void set_reg(cfg_idx_e idx, logic [15:0] value);
      if (idx == CFG_HOLD_TIMEOUT) timeout_ticks = value;
      else cap_ticks = value;
    endfunction

    // Advance the relay state by one accepted word and queue the result it causes.
    function void note_word(in_t w);
      out_t res;
      reply_e reply;
      reply = RPL_NONE;
      case (w.op)
        OP_TICK: begin
          if (mode_on && sel_on) begin
            if (on_ticks != CountMax) on_ticks = on_ticks + 16'd1;
            if (idle_ticks != CountMax) idle_ticks = idle_ticks + 16'd1;
            if (!capped && on_ticks >= cap_ticks) begin
              image = image | (16'd1 << sel_idx);
              capped = 1;
              reply = RPL_CAP;
            end
            if (idle_ticks > timeout_ticks) begin
              if (!capped) image = image | (16'd1 << sel_idx);
              sel_on = 0;
              capped = 0;
            end
          end
        end
        OP_ENTER: begin
          if (w.seq_busy) begin
            reply = RPL_BUSY;
          end else begin
            image = ImageAllOff;
            mode_on = 1;
            sel_on = 0;
            capped = 0;
            reply = RPL_ENTER_ACK;
          end
        end
        OP_EXIT: begin
          image = ImageAllOff;
          mode_on = 0;
          sel_on = 0;
          reply = RPL_EXIT_DONE;
        end
        OP_RELEASE: begin
          if (sel_on) image = image | (16'd1 << sel_idx);
          sel_on = 0;
          capped = 0;
        end
        OP_HOLD: begin
          if (mode_on) begin
            if (w.relay_index > MaxIndex) begin
              reply = RPL_INVALID;
            end else begin
              if (!sel_on || w.relay_index[3:0] != sel_idx) begin
                image = ImageAllOff & ~(16'd1 << w.relay_index[3:0]);
                sel_on = 1;
                sel_idx = w.relay_index[3:0];
                on_ticks = '0;
                capped = 0;
              end
              idle_ticks = '0;
            end
          end
        end
        OP_STOP: begin
          image = ImageAllOff;
          mode_on = 0;
          sel_on = 0;
          capped = 0;
          reply = RPL_STOP_DONE;
        end
        default: ;
      endcase
      res.relays = image;
      res.reply_code = reply;
      res.in_test_mode = mode_on;
      res.held_valid = sel_on;
      res.held_index = sel_on ? sel_idx : 4'd0;
      res.cap_hit = capped;
      due_results.push_back(res);
    endfunction

    function void check_result(out_t got);
      out_t want;
      if (due_results.size() == 0) begin
        fails++;
        if (fails <= 10) $display("result word %h arrived with none expected", got);
        return;
      end
      want = due_results.pop_front();
      if (got.relays !== want.relays || got.reply_code !== want.reply_code ||
          got.in_test_mode !== want.in_test_mode || got.held_valid !== want.held_valid ||
          got.held_index !== want.held_index || got.cap_hit !== want.cap_hit) begin
        fails++;
        if (fails <= 10)
          $display({"mismatch (expected/actual): relays %h/%h reply %0d/%0d mode %b/%b ",
                    "held %b/%b index %0d/%0d cap %b/%b"},
                   want.relays, got.relays, want.reply_code, got.reply_code,
                   want.in_test_mode, got.in_test_mode, want.held_valid, got.held_valid,
                   want.held_index, got.held_index, want.cap_hit, got.cap_hit);
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  in_t         in_data_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  out_t        out_data_o;
  logic        cfg_we_i = 1'b0;
  logic        cfg_index_i = 1'b0;
  logic [15:0] cfg_data_i = '0;

  relay_tracker sb = new();
  bit quiet = 0;
  int run_max = 8;
  int words_sent = 0;
  int cycles = 0;

  dead_man_relay_test_controller u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic int pick_wait();
    if (quiet || $urandom_range(0, 2) == 0) return 0;
    return $urandom_range(0, 16);
  endfunction

  // Enter at a rising edge; return at the edge where the word was taken.
  task automatic send_word(input in_t w);
    int gap;
    gap = pick_wait();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= w;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_word(w);
    words_sent++;
  endtask

  task automatic send(input op_e op, input logic [7:0] idx = 8'd0, input logic busy = 1'b0);
    in_t w;
    w.op = op;
    w.relay_index = idx;
    w.seq_busy = busy;
    send_word(w);
  endtask

  task automatic send_noise();
    logic [InWidth-1:0] raw;
    raw = InWidth'($urandom);
    send_word(in_t'(raw));
  endtask

  // Drop valid and wait until every queued result word has drained.
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.due_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_cfg(input logic [15:0] timeout_val, input logic [15:0] cap_val);
    cfg_we_i <= 1'b1;
    cfg_index_i <= CFG_HOLD_TIMEOUT;
    cfg_data_i <= timeout_val;
    @(posedge clk_i);
    cfg_index_i <= CFG_HARD_CAP;
    cfg_data_i <= cap_val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.set_reg(CFG_HOLD_TIMEOUT, timeout_val);
    sb.set_reg(CFG_HARD_CAP, cap_val);
    if (timeout_val < cap_val) run_max = (timeout_val > 18) ? 20 : timeout_val + 2;
    else run_max = (cap_val > 18) ? 20 : cap_val + 2;
  endtask

  // One test session: enter, a random mix of holds, ticks, releases, enters and noise, then leave or not.
  task automatic random_session();
    int steps;
    int n;
    int pick;
    logic [3:0] last;
    quiet = ($urandom_range(0, 4) == 0);
    last = 4'($urandom_range(0, 15));
    send(OP_ENTER, 8'($urandom), $urandom_range(0, 7) == 0);
    steps = $urandom_range(3, 16);
    repeat (steps) begin
      pick = $urandom_range(0, 11);
      if (pick < 5) begin
        n = $urandom_range(1, run_max);
        repeat (n) send(OP_TICK, 8'($urandom), 1'($urandom));
      end else if (pick < 8) begin
        if ($urandom_range(0, 1) == 1) last = 4'($urandom_range(0, 15));
        send(OP_HOLD, {4'd0, last}, 1'($urandom));
      end else if (pick == 8) begin
        send(OP_RELEASE, 8'($urandom), 1'($urandom));
      end else if (pick == 9) begin
        send(OP_HOLD, 8'($urandom_range(16, 255)), 1'($urandom));
      end else if (pick == 10) begin
        send(OP_ENTER, 8'($urandom), $urandom_range(0, 1) == 0);
      end else begin
        send_noise();
      end
    end
    case ($urandom_range(0, 3))
      0: send(OP_EXIT);
      1: send(OP_STOP);
      default: ;
    endcase
  endtask

  initial begin : result_side
    int n;
    @(posedge rst_ni);
    forever begin
      n = pick_wait();
      if (n > 0) begin
        out_stall_i <= 1'b1;
        repeat (n) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
      sb.check_result(out_data_o);
    end
  end

  initial begin : command_side
    logic [15:0] phase_cfg[8][2];
    int target;
    phase_cfg = '{'{16'd1, 16'd1}, '{16'd3, 16'd6}, '{16'd6, 16'd3}, '{16'd65535, 16'd5},
                  '{16'd10, 16'd65535}, '{16'd2, 16'd4}, '{16'd0, 16'd0}, '{16'd1, 16'd1}};
    phase_cfg[7][0] = 16'($urandom_range(1, 20));
    phase_cfg[7][1] = 16'($urandom_range(1, 30));
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: commands outside test mode, busy refusal, index extremes.
    send(OP_TICK);
    send(OP_HOLD, 8'd3);
    send(OP_RELEASE);
    send(OP_ENTER, 8'd0, 1'b1);
    send(OP_ENTER);
    send(OP_TICK);
    send(OP_HOLD, 8'd0);
    send(OP_HOLD, 8'd15);
    send(OP_HOLD, 8'd15);
    send(OP_HOLD, 8'd16);
    send(OP_HOLD, 8'd255, 1'b1);
    send(OP_TICK);
    send(OP_RELEASE);
    send(OP_HOLD, 8'd7);
    send(OP_ENTER, 8'd0, 1'b1);
    send_word(in_t'({OpSpareLo, 8'd0, 1'b0}));
    send_word(in_t'({OpSpareHi, 8'hFF, 1'b1}));
    send(OP_STOP);
    send(OP_HOLD, 8'd2);
    drain();

    // Zero timeout and cap: both fire on the first tick after a hold.
    write_cfg(16'd0, 16'd0);
    send(OP_ENTER);
    send(OP_HOLD, 8'd2);
    send(OP_TICK);
    send(OP_HOLD, 8'd2);
    send(OP_EXIT);
    drain();

    for (int p = 0; p < 8; p++) begin
      write_cfg(phase_cfg[p][0], phase_cfg[p][1]);
      target = words_sent + 50;
      while (words_sent < target) random_session();
      drain();
    end

    // Top settings: a short run neither reaches the cap nor times out.
    quiet = 1;
    write_cfg(16'd65535, 16'd65535);
    send(OP_ENTER);
    send(OP_HOLD, 8'd9);
    repeat (20) send(OP_TICK);
    send(OP_HOLD, 8'd9);
    send(OP_TICK);
    send(OP_HOLD, 8'd4);
    send(OP_TICK);
    send(OP_STOP);
    quiet = 0;
    drain();

    if (sb.fails == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

### filelist.f
design/dmr_pkg.sv
design/dmr_ctrl.sv
design/dead_man_relay_test_controller.sv
tb/sv/dead_man_relay_test_controller_tb.sv
